// ----- rtl/core/door_drive_state_machine_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Door drive assertion macros
// Shared concurrent assertion forms for the door drive block.
// ----------------------------------------------------------------------------
`ifndef DOOR_DRIVE_STATE_MACHINE_UNIT_ASSERT_SVH
`define DOOR_DRIVE_STATE_MACHINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDSM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("door drive check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DDSM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("door drive check failed");

`endif

// ----- rtl/core/ddsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Door drive package
// Phase codes, switch word layout, register map and reset values.
// ----------------------------------------------------------------------------
package ddsm_pkg;

    // Door motion phases.
    typedef enum logic [3:0] {
        PH_INIT    = 4'd0,
        PH_UNKNOWN = 4'd1,
        PH_OPEN    = 4'd2,
        PH_CLOSED  = 4'd3,
        PH_ACC_POS = 4'd4,
        PH_ACC_NEG = 4'd5,
        PH_RUN_POS = 4'd6,
        PH_RUN_NEG = 4'd7,
        PH_DEC_POS = 4'd8,
        PH_DEC_NEG = 4'd9
    } ddsm_phase_t;

    // Sampled switch levels and direction request for one tick.
    typedef struct packed {
        logic move_dir;
        logic closed_end_switch;
        logic neg_run_switch;
        logic pos_run_switch;
        logic open_end_switch;
    } ddsm_sw_t;

    localparam int SPEED_MAG_W = 15;
    localparam int OUT_SPEED_W = 16;
    localparam int PHASE_W     = 4;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 24;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_FULL_SPEED = 1'b0;
    localparam logic REG_SLOW_SPEED = 1'b1;

    localparam logic [SPEED_MAG_W-1:0] FULL_SPEED_RST = 15'd890;
    localparam logic [SPEED_MAG_W-1:0] SLOW_SPEED_RST = 15'd98;

endpackage

// ----- rtl/core/door_drive_state_machine_unit.sv -----
// ----------------------------------------------------------------------------
// Door drive state machine unit
// Stream front end, APB speed registers and result stage around the phase FSM.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one word per control tick: the four limit-switch levels and
//   the direction request. m_* returns one word per input word: the new door
//   phase and the signed drive speed. Speed magnitudes come from two APB
//   registers (full speed at 0x0, slow speed at 0x4); write them only while
//   no word is in flight.
//   A word accepted on s_* passes through the input register and then the
//   phase and speed registers before m_tvalid goes high. Throughput: one
//   word per clock while m_tready does not stall the result, set by the
//   single pass through the phase transition logic.
//   The phase and speed registers double as the result register: they only
//   advance when the previous result has been taken, so a stalled m_tready
//   holds the result and fills the input register, after which s_tready
//   drops until the receiver takes the pending word.
//   Reset (aresetn low, synchronous) empties both stages, puts the phase at
//   init with zero speed and reloads the speed registers with 890 and 98.
//   The first word after reset always moves the door into homing at
//   positive full speed.
// ----------------------------------------------------------------------------
`include "door_drive_state_machine_unit_assert.svh"

module door_drive_state_machine_unit
    import ddsm_pkg::*;
#(
    parameter int SPEED_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] open_end_switch, [1] pos_run_switch, [2] neg_run_switch,
    // [3] closed_end_switch, [4] move_dir, [7:5] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] door_phase, [19:4] drive_speed (signed), [23:20] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [SPEED_MAG_W-1:0] full_speed_reg, slow_speed_reg;
    logic                   cfg_wr;

    logic                   in_valid_reg, in_valid_next;
    ddsm_sw_t               in_sw_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   step;

    ddsm_phase_t            phase;
    logic [SPEED_WIDTH-1:0] speed;
    logic signed [31:0]     speed_ext;

    // ---------------- configuration registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_speed_reg <= FULL_SPEED_RST;
            slow_speed_reg <= SLOW_SPEED_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_FULL_SPEED) begin
                full_speed_reg <= pwdata[SPEED_MAG_W-1:0];
            end else begin
                slow_speed_reg <= pwdata[SPEED_MAG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_SLOW_SPEED) begin
            prdata = {{(APB_DATA_W-SPEED_MAG_W){1'b0}}, slow_speed_reg};
        end else begin
            prdata = {{(APB_DATA_W-SPEED_MAG_W){1'b0}}, full_speed_reg};
        end
    end

    // ---------------- handshake and stage control ----------------
    // Advance the phase machine when a word waits and the result slot is free.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload: capture on accept, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sw_reg <= s_tdata[4:0];
        end
    end

    // ---------------- phase machine ----------------
    ddsm_fsm #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .sw         (in_sw_reg),
        .full_speed (full_speed_reg),
        .slow_speed (slow_speed_reg),
        .phase      (phase),
        .speed      (speed)
    );

    // Sign-extend the stored speed, then keep the low 16 bits for the port.
    assign speed_ext = 32'(signed'(speed));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-OUT_SPEED_W-PHASE_W){1'b0}},
                       speed_ext[OUT_SPEED_W-1:0], phase};

    // ---------------- checks ----------------
    `DDSM_ASSERT_NOW(a_no_step_while_stalled, aclk, aresetn,
        out_valid_reg && !m_tready, !step)
    `DDSM_ASSERT_NEXT(a_init_left_after_step, aclk, aresetn,
        step, phase != PH_INIT)
    `DDSM_ASSERT_NOW(a_stopped_at_end, aclk, aresetn,
        phase == PH_OPEN || phase == PH_CLOSED, speed == '0)
    `DDSM_ASSERT_NEXT(a_pending_word_kept, aclk, aresetn,
        in_valid_reg && !step, in_valid_reg)

endmodule

// ----- rtl/core/ddsm_fsm.sv -----
// ----------------------------------------------------------------------------
// Door drive phase machine
// Holds the door phase and the speed command; advances once per step.
// ----------------------------------------------------------------------------
module ddsm_fsm
    import ddsm_pkg::*;
#(
    parameter int SPEED_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  ddsm_sw_t               sw,
    input  logic [SPEED_MAG_W-1:0] full_speed,
    input  logic [SPEED_MAG_W-1:0] slow_speed,
    output ddsm_phase_t            phase,
    output logic [SPEED_WIDTH-1:0] speed
);

    ddsm_phase_t            phase_reg, phase_next;
    logic [SPEED_WIDTH-1:0] speed_reg, speed_next;

    logic [31:0]            full_32, slow_32;
    logic [SPEED_WIDTH-1:0] full_pos, full_neg, slow_pos, slow_neg;

    // Bring the 15-bit magnitudes to the speed register width (wrap if narrower).
    assign full_32  = {{(32-SPEED_MAG_W){1'b0}}, full_speed};
    assign slow_32  = {{(32-SPEED_MAG_W){1'b0}}, slow_speed};
    assign full_pos = full_32[SPEED_WIDTH-1:0];
    assign slow_pos = slow_32[SPEED_WIDTH-1:0];
    assign full_neg = -full_pos;
    assign slow_neg = -slow_pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_INIT;
            speed_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            speed_reg <= speed_next;
        end
    end

    // In the moving phases, the switch test wins over the direction test.
    always_comb begin
        phase_next = phase_reg;
        speed_next = speed_reg;
        case (phase_reg)
            PH_INIT: begin
                phase_next = PH_UNKNOWN;
                speed_next = full_pos;
            end
            PH_UNKNOWN: begin
                if (sw.open_end_switch && !sw.move_dir) begin
                    phase_next = PH_OPEN;
                    speed_next = '0;
                end else if (sw.closed_end_switch && sw.move_dir) begin
                    phase_next = PH_CLOSED;
                    speed_next = '0;
                end
            end
            PH_OPEN: begin
                if (sw.move_dir) begin
                    phase_next = PH_ACC_POS;
                    speed_next = slow_pos;
                end
            end
            PH_CLOSED: begin
                if (!sw.move_dir) begin
                    phase_next = PH_ACC_NEG;
                    speed_next = slow_neg;
                end
            end
            PH_ACC_POS: begin
                if (sw.pos_run_switch) begin
                    phase_next = PH_RUN_POS;
                    speed_next = full_pos;
                end else if (!sw.move_dir) begin
                    phase_next = PH_DEC_NEG;
                    speed_next = slow_neg;
                end
            end
            PH_ACC_NEG: begin
                if (sw.neg_run_switch) begin
                    phase_next = PH_RUN_NEG;
                    speed_next = full_neg;
                end else if (sw.move_dir) begin
                    phase_next = PH_DEC_POS;
                    speed_next = slow_pos;
                end
            end
            PH_RUN_POS: begin
                if (sw.neg_run_switch) begin
                    phase_next = PH_DEC_POS;
                    speed_next = slow_pos;
                end else if (!sw.move_dir) begin
                    phase_next = PH_RUN_NEG;
                    speed_next = full_neg;
                end
            end
            PH_RUN_NEG: begin
                if (sw.pos_run_switch) begin
                    phase_next = PH_DEC_NEG;
                    speed_next = slow_neg;
                end else if (sw.move_dir) begin
                    phase_next = PH_RUN_POS;
                    speed_next = full_pos;
                end
            end
            PH_DEC_POS: begin
                if (sw.closed_end_switch) begin
                    phase_next = PH_CLOSED;
                    speed_next = '0;
                end else if (!sw.move_dir) begin
                    phase_next = PH_ACC_NEG;
                    speed_next = slow_neg;
                end
            end
            PH_DEC_NEG: begin
                if (sw.open_end_switch) begin
                    phase_next = PH_OPEN;
                    speed_next = '0;
                end else if (sw.move_dir) begin
                    phase_next = PH_ACC_POS;
                    speed_next = slow_pos;
                end
            end
            default: begin
                phase_next = phase_reg;
                speed_next = speed_reg;
            end
        endcase
    end

    assign phase = phase_reg;
    assign speed = speed_reg;

endmodule
